// File: src/prc_pkg.sv
// Shared types, constants and helpers for the pre-trade risk check.
`timescale 1ns / 1ps
`default_nettype none
package prc_pkg;

   localparam int MoneyWidth = 64;
   localparam int FracBits   = 16;
   localparam int RegIdxWidth = 3;

   localparam logic signed [MoneyWidth-1:0] MoneyMax = {1'b0, {(MoneyWidth-1){1'b1}}};
   localparam logic signed [MoneyWidth-1:0] MoneyMin = {1'b1, {(MoneyWidth-1){1'b0}}};

   typedef enum logic [1:0] {
      ACT_ORDER = 2'd0,
      ACT_FILL  = 2'd1,
      ACT_RESET = 2'd2,
      ACT_NONE  = 2'd3
   } action_type;

   typedef enum logic [3:0] {
      RSN_NONE     = 4'd0,
      RSN_KILL     = 4'd1,
      RSN_QTY      = 4'd2,
      RSN_NOTIONAL = 4'd3,
      RSN_POSITION = 4'd4,
      RSN_GROSS    = 4'd5,
      RSN_NET      = 4'd6,
      RSN_DAILY    = 4'd7,
      RSN_DRAWDOWN = 4'd8
   } reason_type;

   localparam logic [RegIdxWidth-1:0] REG_KILL     = 3'd0;
   localparam logic [RegIdxWidth-1:0] REG_MAX_QTY  = 3'd1;
   localparam logic [RegIdxWidth-1:0] REG_MAX_NOT  = 3'd2;
   localparam logic [RegIdxWidth-1:0] REG_MAX_POS  = 3'd3;
   localparam logic [RegIdxWidth-1:0] REG_MAX_GRS  = 3'd4;
   localparam logic [RegIdxWidth-1:0] REG_MAX_NET  = 3'd5;
   localparam logic [RegIdxWidth-1:0] REG_MAX_LOSS = 3'd6;
   localparam logic [RegIdxWidth-1:0] REG_MAX_DD   = 3'd7;

   typedef struct packed {
      logic        kill;
      logic [31:0] max_qty;
      logic [61:0] max_notional;
      logic [46:0] max_position;
      logic [61:0] max_gross;
      logic [61:0] max_net;
      logic [61:0] max_loss;
      logic [16:0] max_dd;
   } cfg_type;

   // item as passed from the front end to the back end
   typedef struct packed {
      action_type                   action;
      logic                         is_buy;
      logic [31:0]                  qty;
      logic [39:0]                  price;
      logic signed [47:0]           position;
      logic [61:0]                  gross;
      logic signed [62:0]           net;
      logic signed [62:0]           nav;
   } item_type;

   typedef struct packed {
      logic                         order_pass;
      reason_type                   reason;
      logic                         breach_dd;
      logic                         breach_dl;
      logic [16:0]                  drawdown;
      logic signed [MoneyWidth-1:0] daily_pnl;
   } result_type;

   // saturating add of two values already inside the money range
   function automatic logic signed [MoneyWidth-1:0] sat_add(
      input logic signed [MoneyWidth-1:0] a, input logic signed [MoneyWidth-1:0] b);
      logic signed [MoneyWidth:0] s;
      s = {a[MoneyWidth-1], a} + {b[MoneyWidth-1], b};
      if (s[MoneyWidth] != s[MoneyWidth-1])
         return s[MoneyWidth] ? MoneyMin : MoneyMax;
      return s[MoneyWidth-1:0];
   endfunction

   function automatic logic [MoneyWidth-1:0] mag(input logic signed [MoneyWidth-1:0] v);
      return v[MoneyWidth-1] ? (~v + 64'd1) : v;
   endfunction

endpackage
`default_nettype wire

// File: src/prc_front.sv
// Front end: config registers, item capture, price selection, small queue.
`timescale 1ns / 1ps
`default_nettype none
module prc_front import prc_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [63:0] csr_data,
   input  wire logic        in_valid,
   output logic             in_ready,
   input  wire logic [1:0]  in_action,
   input  wire logic        in_is_buy,
   input  wire logic [31:0] in_qty,
   input  wire logic [39:0] in_limit,
   input  wire logic [39:0] in_ref,
   input  wire logic        in_has_ref,
   input  wire logic [47:0] in_pos,
   input  wire logic [61:0] in_gross,
   input  wire logic [62:0] in_net,
   input  wire logic [62:0] in_nav,
   output cfg_type          cfg,
   output logic             q_valid,
   input  wire logic        q_ready,
   output item_type         q_item
);
   localparam int Depth = 2;
   cfg_type  cfg_ff, cfg_in;
   item_type mem_ff [Depth];
   logic     wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   item_type cur;
   logic push, pop;

   assign csr_ready = 1'b1;
   assign cfg = cfg_ff;
   assign in_ready = (cnt_ff != 2'd2);
   assign push = in_valid && in_ready;
   assign pop = q_valid && q_ready;
   assign q_valid = (cnt_ff != 2'd0);
   assign q_item = mem_ff[rp_ff];

   always_comb begin
      cur.action = action_type'(in_action);
      cur.is_buy = in_is_buy;
      cur.qty = in_qty;
      // market order takes the reference price, or zero without one
      if (in_limit != 40'd0) cur.price = in_limit;
      else if (in_has_ref) cur.price = in_ref;
      else cur.price = 40'd0;
      cur.position = in_pos;
      cur.gross = in_gross;
      cur.net = in_net;
      cur.nav = in_nav;
   end

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_KILL:     cfg_in.kill = csr_data[0];
            REG_MAX_QTY:  cfg_in.max_qty = csr_data[31:0];
            REG_MAX_NOT:  cfg_in.max_notional = csr_data[61:0];
            REG_MAX_POS:  cfg_in.max_position = csr_data[46:0];
            REG_MAX_GRS:  cfg_in.max_gross = csr_data[61:0];
            REG_MAX_NET:  cfg_in.max_net = csr_data[61:0];
            REG_MAX_LOSS: cfg_in.max_loss = csr_data[61:0];
            REG_MAX_DD:   cfg_in.max_dd = csr_data[16:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         cfg_ff <= cfg_in;
         if (push) begin
            mem_ff[wp_ff] <= cur;
            wp_ff <= ~wp_ff;
         end
         if (pop) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   assert property (@(posedge clock) disable iff (reset) cnt_ff <= 2'd2)
      else $error("queue overfilled");
   assert property (@(posedge clock) disable iff (reset) (cnt_ff == 2'd2) |-> !push)
      else $error("push into full queue");
   assert property (@(posedge clock) disable iff (reset) (cnt_ff == 2'd0) |-> !pop)
      else $error("pop from empty queue");
endmodule
`default_nettype wire

// File: src/prc_back.sv
// Back end: order checks, NAV tracking with serial drawdown divider, result register.
`timescale 1ns / 1ps
`default_nettype none
module prc_back import prc_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   input  cfg_type    cfg,
   input  wire logic  q_valid,
   output logic       q_ready,
   input  item_type   q_item,
   output logic       out_valid,
   input  wire logic  out_ready,
   output result_type out_res
);
   typedef enum logic [2:0] {
      S_IDLE, S_ORD1, S_ORD2, S_FILL, S_DIV, S_DONE
   } state_type;

   localparam int CntW = $clog2(FracBits + 1);

   state_type state_ff;
   item_type  it_ff;
   logic signed [MoneyWidth-1:0] hwm_ff, dd_pnl_ff, prev_ff, nav_ff;
   logic [16:0] dd_ff;
   logic [MoneyWidth:0] rem_ff;
   logic [FracBits-1:0] quo_ff;
   logic [CntW-1:0] cnt_ff;
   logic [MoneyWidth-1:0] notional_ff;
   logic mul_ovf_ff;
   logic out_valid_ff;
   result_type res_ff;
   result_type res_out_ff;

   // combinational helpers
   logic [71:0] prod;
   logic [MoneyWidth-1:0] notional;
   logic signed [MoneyWidth-1:0] pos_post, gross_after, net_after, nav_c, diff_pnl;
   logic signed [MoneyWidth:0] diff_w;
   reason_type rsn;
   logic [MoneyWidth:0] rem_sh;
   logic [MoneyWidth-1:0] dd_diff;

   assign prod = it_ff.price * it_ff.qty;
   assign notional = mul_ovf_ff ? MoneyMax : notional_ff;
   assign nav_c = {{(MoneyWidth-63){it_ff.nav[62]}}, it_ff.nav};
   assign diff_w = {hwm_ff[MoneyWidth-1], hwm_ff} - {nav_ff[MoneyWidth-1], nav_ff};
   assign dd_diff = diff_w[MoneyWidth-1:0];
   assign rem_sh = {rem_ff[MoneyWidth-1:0], 1'b0};

   always_comb begin
      logic signed [MoneyWidth-1:0] n_s;
      n_s = signed'(notional);
      pos_post = {{(MoneyWidth-48){it_ff.position[47]}}, it_ff.position};
      pos_post = it_ff.is_buy ? pos_post + signed'({32'd0, it_ff.qty})
                              : pos_post - signed'({32'd0, it_ff.qty});
      gross_after = sat_add(signed'({2'b00, it_ff.gross}), n_s);
      net_after = sat_add({it_ff.net[62], it_ff.net}, it_ff.is_buy ? n_s : -n_s);
      if (cfg.kill) rsn = RSN_KILL;
      else if (it_ff.qty > cfg.max_qty) rsn = RSN_QTY;
      else if (notional > {2'b00, cfg.max_notional}) rsn = RSN_NOTIONAL;
      else if (mag(pos_post) > {17'd0, cfg.max_position}) rsn = RSN_POSITION;
      else if (gross_after > 0 && gross_after > signed'({2'b00, cfg.max_gross}))
         rsn = RSN_GROSS;
      else if (mag(net_after) > {2'b00, cfg.max_net}) rsn = RSN_NET;
      else if (dd_pnl_ff < -signed'({2'b00, cfg.max_loss})) rsn = RSN_DAILY;
      else if (dd_ff > cfg.max_dd) rsn = RSN_DRAWDOWN;
      else rsn = RSN_NONE;
   end

   // NAV difference from previous NAV, 65-bit then clamped
   always_comb begin
      logic signed [MoneyWidth:0] d;
      d = {nav_ff[MoneyWidth-1], nav_ff} - {prev_ff[MoneyWidth-1], prev_ff};
      if (d > signed'({1'b0, MoneyMax})) diff_pnl = MoneyMax;
      else if (d < signed'({1'b1, MoneyMin})) diff_pnl = MoneyMin;
      else diff_pnl = d[MoneyWidth-1:0];
   end

   assign q_ready = (state_ff == S_IDLE);
   assign out_valid = out_valid_ff;
   assign out_res = res_out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         out_valid_ff <= 1'b0;
         hwm_ff <= '0;
         dd_ff <= '0;
         dd_pnl_ff <= '0;
         prev_ff <= '0;
      end else begin
         if (out_valid_ff && out_ready && state_ff != S_DONE) out_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (q_valid) begin
                  it_ff <= q_item;
                  unique case (q_item.action)
                     ACT_ORDER: state_ff <= S_ORD1;
                     ACT_FILL:  state_ff <= S_FILL;
                     ACT_RESET: begin
                        dd_pnl_ff <= '0;
                        res_ff <= '{1'b1, RSN_NONE, 1'b0, 1'b0, dd_ff, '0};
                        state_ff <= S_DONE;
                     end
                     default: begin
                        res_ff <= '{1'b1, RSN_NONE, 1'b0, 1'b0, dd_ff, dd_pnl_ff};
                        state_ff <= S_DONE;
                     end
                  endcase
               end
            end
            S_ORD1: begin
               notional_ff <= prod[MoneyWidth-1:0];
               mul_ovf_ff <= (prod[71:MoneyWidth-1] != '0);
               state_ff <= S_ORD2;
            end
            S_ORD2: begin
               res_ff <= '{(rsn == RSN_NONE), rsn, 1'b0, 1'b0, dd_ff, dd_pnl_ff};
               state_ff <= S_DONE;
            end
            S_FILL: begin
               nav_ff <= nav_c;
               if (nav_c > hwm_ff) hwm_ff <= nav_c;
               state_ff <= S_DIV;
               cnt_ff <= '0;
               quo_ff <= '0;
               rem_ff <= '0;
            end
            S_DIV: begin
               // first cycle seeds the remainder, then one quotient bit a cycle
               if (hwm_ff <= 0) begin
                  cnt_ff <= CntW'(FracBits);
               end else if (cnt_ff == '0 && rem_ff == '0 && quo_ff == '0) begin
                  if (diff_w >= signed'({1'b0, hwm_ff})) begin
                     dd_ff <= 17'(1 << FracBits);
                     cnt_ff <= CntW'(FracBits);
                     rem_ff <= '1;
                  end else begin
                     rem_ff <= {1'b0, dd_diff};
                     cnt_ff <= cnt_ff;
                     quo_ff <= '0;
                     if (dd_diff == '0) begin
                        dd_ff <= '0;
                        cnt_ff <= CntW'(FracBits);
                        rem_ff <= '1;
                     end
                  end
               end else if (cnt_ff < CntW'(FracBits)) begin
                  if (rem_sh >= {1'b0, hwm_ff}) begin
                     rem_ff <= rem_sh - {1'b0, hwm_ff};
                     quo_ff <= {quo_ff[FracBits-2:0], 1'b1};
                  end else begin
                     rem_ff <= rem_sh;
                     quo_ff <= {quo_ff[FracBits-2:0], 1'b0};
                  end
                  cnt_ff <= cnt_ff + 1'b1;
                  if (cnt_ff == CntW'(FracBits - 1))
                     dd_ff <= {1'b0, quo_ff[FracBits-2:0],
                               (rem_sh >= {1'b0, hwm_ff})};
               end
               if (cnt_ff == CntW'(FracBits)) begin
                  logic signed [MoneyWidth-1:0] np;
                  np = (prev_ff > 0) ? sat_add(dd_pnl_ff, diff_pnl) : dd_pnl_ff;
                  dd_pnl_ff <= np;
                  prev_ff <= nav_ff;
                  res_ff <= '{1'b1, RSN_NONE,
                              (hwm_ff > 0) && (dd_ff > cfg.max_dd),
                              np < -signed'({2'b00, cfg.max_loss}), dd_ff, np};
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               if (!out_valid_ff || out_ready) begin
                  out_valid_ff <= 1'b1;
                  res_out_ff <= res_ff;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && (!out_valid_ff || out_ready)) |=> out_valid_ff)
      else $error("result not posted");
   assert property (@(posedge clock) disable iff (reset) dd_ff <= 17'(1 << FracBits))
      else $error("drawdown above one");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> cnt_ff <= CntW'(FracBits))
      else $error("divider count overrun");
endmodule
`default_nettype wire

// File: src/pretrade_risk_check.sv
// Top level of the pre-trade risk check.
// From accept to rsp_tvalid: an order passes ORD1, ORD2, DONE; a fill passes FILL, the
// radix-2 drawdown divider DIV (16 quotient bits) and DONE; a daily reset or unused
// action goes to DONE alone. Throughput: one item in flight in the back end until
// its result is posted, plus any rsp_tready stall. A two-entry queue lets requests be
// taken while the back end works. Sync active-high reset clears cfg, tracking, queue.
`timescale 1ns / 1ps
`default_nettype none
module pretrade_risk_check import prc_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [2:0]   csr_index,
   input  wire logic [63:0]  csr_data,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // action[1:0], is_buy, order_qty[32], lim_px[40], reference_price[40],
   // has_reference_price, position_qty[48], gross_exp[62], net_exp[63],
   // nav_value[63]
   input  wire logic [351:0] req_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // order_pass, reject_reason[4], breach_drawdown, breach_daily_loss,
   // drawdown_now[17], daily_pnl_now[64], zero fill
   output logic [95:0]       rsp_tdata
);
   cfg_type    cfg;
   logic       q_valid, q_ready;
   item_type   q_item;
   result_type res;

   prc_front u_front (
      .clock, .reset, .csr_valid, .csr_ready, .csr_index, .csr_data,
      .in_valid(req_tvalid), .in_ready(req_tready),
      .in_action(req_tdata[1:0]), .in_is_buy(req_tdata[2]),
      .in_qty(req_tdata[34:3]), .in_limit(req_tdata[74:35]),
      .in_ref(req_tdata[114:75]), .in_has_ref(req_tdata[115]),
      .in_pos(req_tdata[163:116]), .in_gross(req_tdata[225:164]),
      .in_net(req_tdata[288:226]), .in_nav(req_tdata[351:289]),
      .cfg, .q_valid, .q_ready, .q_item
   );

   prc_back u_back (
      .clock, .reset, .cfg, .q_valid, .q_ready, .q_item,
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_res(res)
   );

   assign rsp_tdata = {8'd0, res.daily_pnl, res.drawdown, res.breach_dl, res.breach_dd,
                       res.reason, res.order_pass};
endmodule
`default_nettype wire
